/* src/tds_pkg.sv */
// shared types, widths and constants of the tridiagonal solver
package tds_pkg;

   localparam int DATA_W      = 32;
   localparam int FRAC_W      = 16;
   localparam int MAX_ROWS    = 64;
   localparam int STORE_DEPTH = 64;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int DIV_STEPS   = DATA_W + FRAC_W;

   typedef logic signed [DATA_W-1:0] q_type;
   typedef logic [ADDR_W-1:0]        addr_type;

   localparam q_type Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam q_type Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

endpackage

/* src/tridiagonal_system_solver_top.sv */
// tridiagonal solver top level: row sequencer, factor stores, shared units
//
// Rows of a tridiagonal system enter on the req_ channel (valid/ready), one
// transfer per row. Forward elimination runs while the row is held: two
// shared-multiplier passes for the pivot and the right-hand side, then two
// divisions on the bit-serial divider (48 quotient bits, one a cycle). The
// P and Q factors go into two 64 x 32 memories. A row whose pivot is zero
// skips both divisions and stores zero factors.
// A row with req_last_row set, or the 64th row, closes the system: back
// substitution then walks the stored rows, each by a memory read, two
// multiplier stages and a saturating add, and writes x over P. The results
// then leave on the rsp_ channel in index order, each read only after the
// one before is transferred; rsp_ holds its payload while rsp_ready is low
// and no new row is taken until the last result is transferred.
// Reset (synchronous, active high) empties the row count and the zero-pivot
// flag; memory contents are not cleared and need no clearing.
module tridiagonal_system_solver_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tds_pkg::q_type    req_upper_coef,
   input  tds_pkg::q_type    req_diag_coef,
   input  tds_pkg::q_type    req_lower_coef,
   input  tds_pkg::q_type    req_rhs_value,
   input  logic              req_last_row,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tds_pkg::q_type    rsp_solution_value,
   output tds_pkg::addr_type rsp_solution_index,
   output logic              rsp_pivot_zero,
   output logic              rsp_last_result
);
   import tds_pkg::*;

   localparam addr_type LAST_IDX = ADDR_W'(MAX_ROWS - 1);

   typedef enum logic [4:0] {
      S_IDLE,
      S_FETCH,
      S_MUL_P,
      S_MUL_Q,
      S_PIVOT,
      S_QNUM,
      S_DIV_P,
      S_DIV_P_WAIT,
      S_DIV_Q,
      S_DIV_Q_WAIT,
      S_WRITE,
      S_BS_READ,
      S_BS_MUL,
      S_BS_WAIT,
      S_BS_ADD,
      S_EM_READ,
      S_EM_LOAD,
      S_EM_WAIT
   } state_type;

   // saturate a 33-bit sum to 32 bits
   function automatic q_type sat33(input logic signed [DATA_W:0] s);
      if (s[DATA_W] == s[DATA_W-1]) begin
         return q_type'(s[DATA_W-1:0]);
      end else if (s[DATA_W]) begin
         return Q_MIN;
      end else begin
         return Q_MAX;
      end
   endfunction

   state_type state_ff, state_in;
   addr_type  row_cnt_ff, row_cnt_in;
   logic      pivot_err_ff, pivot_err_in;
   logic      rsp_valid_ff, rsp_valid_in;
   q_type     up_ff, up_in;
   q_type     dg_ff, dg_in;
   q_type     lo_ff, lo_in;
   q_type     rh_ff, rh_in;
   logic      closing_ff, closing_in;
   q_type     pprev_ff, pprev_in;
   q_type     qprev_ff, qprev_in;
   q_type     piv_ff, piv_in;
   q_type     qn_ff, qn_in;
   q_type     p_new_ff, p_new_in;
   q_type     q_new_ff, q_new_in;
   q_type     x_ff, x_in;
   q_type     qk_ff, qk_in;
   addr_type  k_ff, k_in;
   addr_type  e_ff, e_in;
   q_type     out_value_ff, out_value_in;
   addr_type  out_index_ff, out_index_in;
   logic      out_pivot_ff, out_pivot_in;
   logic      out_last_ff, out_last_in;

   logic                    req_xfer;
   logic                    rsp_xfer;
   logic                    closing_now;
   addr_type                rd_addr;
   logic                    p_we;
   logic                    q_we;
   addr_type                p_wr_addr;
   q_type                   p_wr_data;
   logic [DATA_W-1:0]       p_rd_raw;
   logic [DATA_W-1:0]       q_rd_raw;
   q_type                   p_rd;
   q_type                   q_rd;
   q_type                   mul_a;
   q_type                   mul_b;
   q_type                   mul_res;
   logic                    div_start;
   logic signed [DATA_W:0]  div_num;
   logic                    div_done;
   q_type                   div_quot;

   assign req_xfer    = req_valid && req_ready;
   assign rsp_xfer    = rsp_valid && rsp_ready;
   assign closing_now = req_last_row || (row_cnt_ff == LAST_IDX);
   assign p_rd        = q_type'(p_rd_raw);
   assign q_rd        = q_type'(q_rd_raw);

   // factor stores; P is overwritten with x during back substitution
   tds_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_p_store (
      .clock   (clock),
      .wr_en   (p_we),
      .wr_addr (p_wr_addr),
      .wr_data (p_wr_data),
      .rd_addr (rd_addr),
      .rd_data (p_rd_raw)
   );

   tds_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_q_store (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (row_cnt_ff),
      .wr_data (q_new_ff),
      .rd_addr (rd_addr),
      .rd_data (q_rd_raw)
   );

   // shared arithmetic units
   tds_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_res)
   );

   tds_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (piv_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // datapath steering by state
   always_comb begin
      rd_addr   = row_cnt_ff - 1'b1;
      p_we      = 1'b0;
      q_we      = 1'b0;
      p_wr_addr = row_cnt_ff;
      p_wr_data = closing_ff ? q_new_ff : p_new_ff;
      mul_a     = lo_ff;
      mul_b     = pprev_ff;
      div_start = 1'b0;
      div_num   = -{up_ff[DATA_W-1], up_ff};
      x_in      = sat33({mul_res[DATA_W-1], mul_res} + {qk_ff[DATA_W-1], qk_ff});
      case (state_ff)
         S_MUL_Q: begin
            mul_b = qprev_ff;
         end
         S_DIV_P: begin
            div_start = 1'b1;
         end
         S_DIV_Q: begin
            div_start = 1'b1;
            div_num   = {qn_ff[DATA_W-1], qn_ff};
         end
         S_WRITE: begin
            p_we = 1'b1;
            q_we = 1'b1;
         end
         S_BS_READ: begin
            rd_addr = k_ff - 1'b1;
         end
         S_BS_MUL: begin
            mul_a = p_rd;
            mul_b = x_ff;
         end
         S_BS_ADD: begin
            p_we      = 1'b1;
            p_wr_addr = k_ff - 1'b1;
            p_wr_data = x_in;
         end
         S_EM_READ: begin
            rd_addr = e_ff;
         end
         default: begin
         end
      endcase
   end

   // row sequencer
   always_comb begin
      state_in     = state_ff;
      row_cnt_in   = row_cnt_ff;
      pivot_err_in = pivot_err_ff;
      rsp_valid_in = rsp_valid_ff;
      up_in        = up_ff;
      dg_in        = dg_ff;
      lo_in        = lo_ff;
      rh_in        = rh_ff;
      closing_in   = closing_ff;
      pprev_in     = pprev_ff;
      qprev_in     = qprev_ff;
      piv_in       = piv_ff;
      qn_in        = qn_ff;
      p_new_in     = p_new_ff;
      q_new_in     = q_new_ff;
      qk_in        = qk_ff;
      k_in         = k_ff;
      e_in         = e_ff;
      out_value_in = out_value_ff;
      out_index_in = out_index_ff;
      out_pivot_in = out_pivot_ff;
      out_last_in  = out_last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               up_in      = closing_now ? '0 : req_upper_coef;
               dg_in      = req_diag_coef;
               lo_in      = (row_cnt_ff == '0) ? '0 : req_lower_coef;
               rh_in      = req_rhs_value;
               closing_in = closing_now;
               state_in   = S_FETCH;
            end
         end
         S_FETCH: begin
            pprev_in = (row_cnt_ff == '0) ? '0 : p_rd;
            qprev_in = (row_cnt_ff == '0) ? '0 : q_rd;
            state_in = S_MUL_P;
         end
         S_MUL_P: begin
            state_in = S_MUL_Q;
         end
         S_MUL_Q: begin
            state_in = S_PIVOT;
         end
         S_PIVOT: begin
            piv_in   = sat33({dg_ff[DATA_W-1], dg_ff} + {mul_res[DATA_W-1], mul_res});
            state_in = S_QNUM;
         end
         S_QNUM: begin
            qn_in = sat33({rh_ff[DATA_W-1], rh_ff} - {mul_res[DATA_W-1], mul_res});
            if (piv_ff == '0) begin
               pivot_err_in = 1'b1;
               p_new_in     = '0;
               q_new_in     = '0;
               state_in     = S_WRITE;
            end else begin
               state_in = S_DIV_P;
            end
         end
         S_DIV_P: begin
            state_in = S_DIV_P_WAIT;
         end
         S_DIV_P_WAIT: begin
            if (div_done) begin
               p_new_in = div_quot;
               state_in = S_DIV_Q;
            end
         end
         S_DIV_Q: begin
            state_in = S_DIV_Q_WAIT;
         end
         S_DIV_Q_WAIT: begin
            if (div_done) begin
               q_new_in = div_quot;
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            if (!closing_ff) begin
               row_cnt_in = row_cnt_ff + 1'b1;
               state_in   = S_IDLE;
            end else begin
               k_in = row_cnt_ff;
               e_in = '0;
               state_in = (row_cnt_ff == '0) ? S_EM_READ : S_BS_READ;
            end
         end
         S_BS_READ: begin
            state_in = S_BS_MUL;
         end
         S_BS_MUL: begin
            qk_in    = q_rd;
            state_in = S_BS_WAIT;
         end
         S_BS_WAIT: begin
            state_in = S_BS_ADD;
         end
         S_BS_ADD: begin
            k_in     = k_ff - 1'b1;
            state_in = (k_ff == addr_type'(1)) ? S_EM_READ : S_BS_READ;
         end
         S_EM_READ: begin
            state_in = S_EM_LOAD;
         end
         S_EM_LOAD: begin
            out_value_in = p_rd;
            out_index_in = e_ff;
            out_pivot_in = pivot_err_ff;
            out_last_in  = (e_ff == row_cnt_ff);
            rsp_valid_in = 1'b1;
            state_in     = S_EM_WAIT;
         end
         S_EM_WAIT: begin
            if (rsp_xfer) begin
               rsp_valid_in = 1'b0;
               if (out_last_ff) begin
                  row_cnt_in   = '0;
                  pivot_err_in = 1'b0;
                  state_in     = S_IDLE;
               end else begin
                  e_in     = e_ff + 1'b1;
                  state_in = S_EM_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         row_cnt_ff   <= '0;
         pivot_err_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_cnt_ff   <= row_cnt_in;
         pivot_err_ff <= pivot_err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      up_ff        <= up_in;
      dg_ff        <= dg_in;
      lo_ff        <= lo_in;
      rh_ff        <= rh_in;
      closing_ff   <= closing_in;
      pprev_ff     <= pprev_in;
      qprev_ff     <= qprev_in;
      piv_ff       <= piv_in;
      qn_ff        <= qn_in;
      p_new_ff     <= p_new_in;
      q_new_ff     <= q_new_in;
      qk_ff        <= qk_in;
      k_ff         <= k_in;
      e_ff         <= e_in;
      out_value_ff <= out_value_in;
      out_index_ff <= out_index_in;
      out_pivot_ff <= out_pivot_in;
      out_last_ff  <= out_last_in;
      if (state_ff == S_WRITE || state_ff == S_BS_ADD) begin
         x_ff <= (state_ff == S_WRITE) ? q_new_ff : x_in;
      end
   end

   assign req_ready          = (state_ff == S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_solution_value = out_value_ff;
   assign rsp_solution_index = out_index_ff;
   assign rsp_pivot_zero     = out_pivot_ff;
   assign rsp_last_result    = out_last_ff;

   // a result is never offered while rows are taken
   assert property (@(posedge clock) disable iff (reset) !(rsp_valid && req_ready))
      else $error("result offered while accepting rows");

   // the final result transfer hands control back to row loading
   assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && rsp_last_result) |=> (req_ready && !rsp_valid))
      else $error("block not idle after final result");

   // a row transfer always starts elimination
   assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == S_FETCH))
      else $error("row transfer did not start elimination");

   // divider completes only while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV_P_WAIT || state_ff == S_DIV_Q_WAIT))
      else $error("divider finished outside a wait state");

endmodule

/* src/tds_ram.sv */
// generic single write port, single read port memory with registered read
module tds_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

/* src/tds_mul.sv */
// shared two-stage Q16.16 multiplier with round-to-nearest and saturation
module tds_mul (
   input  logic          clock,
   input  tds_pkg::q_type op_a,
   input  tds_pkg::q_type op_b,
   output tds_pkg::q_type product
);
   import tds_pkg::*;

   localparam int PROD_W = 2 * DATA_W;
   localparam int SHR_W  = PROD_W - FRAC_W;
   localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(1) << (FRAC_W - 1);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] rnd;
   logic        [SHR_W-1:0]  shr;
   logic        [SHR_W-DATA_W:0] hi_bits;
   q_type                     res_ff;
   q_type                     res_in;

   // stage one: full product
   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   // stage two: add half an lsb, floor by dropping fraction, clamp
   always_comb begin
      rnd     = prod_ff + HALF_LSB;
      shr     = rnd[PROD_W-1:FRAC_W];
      hi_bits = shr[SHR_W-1:DATA_W-1];
      if (hi_bits == '0 || hi_bits == '1) begin
         res_in = q_type'(shr[DATA_W-1:0]);
      end else if (shr[SHR_W-1]) begin
         res_in = Q_MIN;
      end else begin
         res_in = Q_MAX;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      res_ff  <= res_in;
   end

   assign product = res_ff;

endmodule

/* src/tds_div.sv */
// restoring divider, one quotient bit a cycle, (num * 2^16) / den, saturated
module tds_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic signed [tds_pkg::DATA_W:0] num,
   input  tds_pkg::q_type                  den,
   output logic                           done,
   output tds_pkg::q_type                  quot
);
   import tds_pkg::*;

   localparam int CNT_W = $clog2(DIV_STEPS);
   localparam int DVD_W = DIV_STEPS;

   logic              busy_ff, busy_in;
   logic              fin_ff, fin_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [DATA_W-1:0] dmag_ff, dmag_in;
   logic              neg_ff, neg_in;

   logic [DATA_W:0]   num_abs;
   logic [DATA_W:0]   den_abs;
   logic [DATA_W:0]   rem_sh;
   logic [DATA_W+1:0] diff;
   logic              ge;
   logic              pos_ovf;
   logic              neg_ovf;
   q_type             mag_lo;

   // operand magnitudes
   always_comb begin
      num_abs = num[DATA_W] ? (DATA_W+1)'(-num) : (DATA_W+1)'(num);
      den_abs = den[DATA_W-1] ? (DATA_W+1)'(-{den[DATA_W-1], den})
                              : {den[DATA_W-1], den};
   end

   // one trial subtraction a cycle
   always_comb begin
      rem_sh = {rem_ff, dvd_ff[DVD_W-1]};
      diff   = {1'b0, rem_sh} - {2'b00, dmag_ff};
      ge     = ~diff[DATA_W+1];
   end

   // iteration control
   always_comb begin
      busy_in = busy_ff;
      fin_in  = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dmag_in = dmag_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvd_in  = {num_abs[DATA_W-1:0], {FRAC_W{1'b0}}};
         dmag_in = den_abs[DATA_W-1:0];
         neg_in  = num[DATA_W] ^ den[DATA_W-1];
      end else if (busy_ff) begin
         rem_in = ge ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
         dvd_in = {dvd_ff[DVD_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      dmag_ff <= dmag_in;
      neg_ff  <= neg_in;
   end

   // signed, saturated quotient from the magnitude
   always_comb begin
      mag_lo  = q_type'(dvd_ff[DATA_W-1:0]);
      pos_ovf = |dvd_ff[DVD_W-1:DATA_W-1];
      neg_ovf = (|dvd_ff[DVD_W-1:DATA_W]) ||
                (dvd_ff[DATA_W-1] && (|dvd_ff[DATA_W-2:0]));
      if (neg_ff) begin
         quot = neg_ovf ? Q_MIN : -mag_lo;
      end else begin
         quot = pos_ovf ? Q_MAX : mag_lo;
      end
   end

   assign done = fin_ff;

endmodule

/* test/tridiagonal_system_solver_top_tb.sv */
// self-checking testbench for the tridiagonal solver: directed rows, random systems
`timescale 1ns / 1ps

module tridiagonal_system_solver_top_tb;
   import tds_pkg::*;

   localparam int STALL_LIMIT = 5000;
   localparam int LONG_HOLD   = 600;
   localparam int DRAIN_WAIT  = 400;
   localparam int RANDOM_ROWS = 390;

   // one row of a system, with the solution typed in for single-row systems
   typedef struct packed {
      q_type up;
      q_type dg;
      q_type lo;
      q_type rh;
      logic  last;
      logic  known;
      q_type x_known;
      logic  pz_known;
   } row_stim_type;

   typedef struct packed {
      q_type    sol_value;
      addr_type sol_index;
      logic     pivot_zero;
      logic     last;
   } solution_type;

   localparam q_type ONE = 32'h0001_0000;

   localparam row_stim_type DIRECTED [17] = '{
      // single-row systems: x = rhs / diag, first-row lower and closing upper ignored
      '{32'h0000_0000, ONE,          32'h0000_0000, 32'h0005_0000, 1'b1,
        1'b1, 32'h0005_0000, 1'b0},
      '{32'h0001_0000, 32'h0000_0000, 32'h0001_0000, 32'h1234_5678, 1'b1,
        1'b1, 32'h0000_0000, 1'b1},
      '{Q_MIN,         ONE,          Q_MAX,         Q_MAX,         1'b1,
        1'b1, Q_MAX,         1'b0},
      '{Q_MAX,         32'h0000_0001, Q_MIN,        Q_MIN,         1'b1,
        1'b1, Q_MIN,         1'b0},
      '{32'hFFFF_FFFF, 32'hFFFF_0000, 32'hFFFF_FFFF, Q_MAX,        1'b1,
        1'b1, 32'h8000_0001, 1'b0},
      // four rows at the extremes
      '{Q_MIN, Q_MAX, Q_MIN, Q_MAX, 1'b0, 1'b0, '0, 1'b0},
      '{Q_MAX, Q_MIN, Q_MAX, Q_MIN, 1'b0, 1'b0, '0, 1'b0},
      '{32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0,
        1'b0, '0, 1'b0},
      '{Q_MAX, 32'h0002_0000, 32'hFFFF_8000, 32'h0003_0000, 1'b1, 1'b0, '0, 1'b0},
      // zero pivot in the middle of a system
      '{32'h0000_0000, ONE, 32'h0000_0000, ONE, 1'b0, 1'b0, '0, 1'b0},
      '{ONE, 32'h0000_0000, ONE, 32'h0002_0000, 1'b0, 1'b0, '0, 1'b0},
      '{32'h0000_0000, 32'h0002_0000, ONE, 32'h0003_0000, 1'b1, 1'b0, '0, 1'b0},
      // pivot cancelled by the elimination term on the closing row
      '{32'hFFFF_0000, ONE, 32'h0000_0000, ONE, 1'b0, 1'b0, '0, 1'b0},
      '{32'h0003_0000, 32'hFFFF_0000, ONE, 32'h0000_0005, 1'b1, 1'b0, '0, 1'b0},
      // ordinary diagonally dominant rows
      '{32'h0000_8000, 32'h0004_0000, 32'h0000_4000, ONE, 1'b0, 1'b0, '0, 1'b0},
      '{32'hFFFF_0000, 32'h0003_0000, ONE, 32'hFFFE_0000, 1'b0, 1'b0, '0, 1'b0},
      '{32'h0001_8000, 32'h0005_0000, 32'hFFFF_8000, 32'h0002_8000, 1'b1,
        1'b0, '0, 1'b0}
   };

   logic     clock = 1'b0;
   logic     reset;
   logic     req_valid;
   logic     req_ready;
   q_type    req_upper_coef;
   q_type    req_diag_coef;
   q_type    req_lower_coef;
   q_type    req_rhs_value;
   logic     req_last_row;
   logic     rsp_valid;
   logic     rsp_ready;
   q_type    rsp_solution_value;
   addr_type rsp_solution_index;
   logic     rsp_pivot_zero;
   logic     rsp_last_result;

   // forward elimination copy and expected solutions
   q_type        fwd_p [STORE_DEPTH];
   q_type        fwd_q [STORE_DEPTH];
   int unsigned  rows_loaded = 0;
   logic         pivot_seen = 1'b0;
   solution_type pending_solutions [$];

   int   mismatch_count = 0;
   int   stall_cycles = 0;
   logic steady;
   int   hold_calls;

   tridiagonal_system_solver_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_upper_coef     (req_upper_coef),
      .req_diag_coef      (req_diag_coef),
      .req_lower_coef     (req_lower_coef),
      .req_rhs_value      (req_rhs_value),
      .req_last_row       (req_last_row),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_solution_value (rsp_solution_value),
      .rsp_solution_index (rsp_solution_index),
      .rsp_pivot_zero     (rsp_pivot_zero),
      .rsp_last_result    (rsp_last_result)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Q16.16 helpers: saturate, rounded product, truncating quotient
   function automatic q_type clamp_q(longint v);
      if (v > 64'sd2147483647) return Q_MAX;
      if (v < -64'sd2147483648) return Q_MIN;
      return q_type'(v);
   endfunction

   function automatic q_type fx_mul(q_type a, q_type b);
      longint prod;
      prod = longint'(a) * longint'(b);
      return clamp_q((prod + 64'sd32768) >>> 16);
   endfunction

   function automatic q_type fx_div(longint num, q_type den);
      return clamp_q((num * 64'sd65536) / longint'(den));
   endfunction

   // eliminate one row; on the closing row back-substitute and queue the solutions
   function automatic void eliminate_row(row_stim_type r);
      int unsigned idx;
      logic        closing;
      longint      up;
      q_type       lo;
      q_type       p_prev;
      q_type       q_prev;
      q_type       pivot;
      q_type       num;
      q_type       xs [STORE_DEPTH];
      idx     = rows_loaded;
      closing = r.last || (idx + 1 >= MAX_ROWS);
      up      = closing ? 64'sd0 : longint'(r.up);
      lo      = (idx == 0) ? q_type'(0) : r.lo;
      p_prev  = (idx == 0) ? q_type'(0) : fwd_p[idx-1];
      q_prev  = (idx == 0) ? q_type'(0) : fwd_q[idx-1];
      pivot   = clamp_q(longint'(r.dg) + longint'(fx_mul(lo, p_prev)));
      if (pivot == 0) begin
         pivot_seen = 1'b1;
         fwd_p[idx] = '0;
         fwd_q[idx] = '0;
      end else begin
         num = clamp_q(longint'(r.rh) - longint'(fx_mul(lo, q_prev)));
         fwd_p[idx] = fx_div(-up, pivot);
         fwd_q[idx] = fx_div(longint'(num), pivot);
      end
      if (!closing) begin
         rows_loaded = idx + 1;
         return;
      end
      xs[idx] = fwd_q[idx];
      for (int k = idx; k > 0; k--)
         xs[k-1] = clamp_q(longint'(fx_mul(fwd_p[k-1], xs[k])) + longint'(fwd_q[k-1]));
      for (int k = 0; k <= idx; k++)
         pending_solutions.push_back('{sol_value: xs[k], sol_index: addr_type'(k),
                                       pivot_zero: pivot_seen, last: (k == idx)});
      rows_loaded = 0;
      pivot_seen  = 1'b0;
   endfunction

   function automatic q_type edge_value();
      case ($urandom_range(4))
         0: return Q_MAX;
         1: return Q_MIN;
         2: return q_type'(0);
         3: return q_type'(1);
         default: return q_type'(-1);
      endcase
   endfunction

   function automatic q_type signed_range(int unsigned lo_mag, int unsigned hi_mag);
      int mag;
      mag = int'($urandom_range(hi_mag, lo_mag));
      return q_type'($urandom_range(1) ? mag : -mag);
   endfunction

   // mostly diagonally dominant rows, some raw noise, extremes and zero diagonals
   function automatic row_stim_type random_row(logic closing);
      row_stim_type r;
      int           sel;
      r   = '0;
      sel = $urandom_range(99);
      if (sel < 12) begin
         r.up = $urandom;
         r.dg = $urandom;
         r.lo = $urandom;
         r.rh = $urandom;
      end else if (sel < 17) begin
         r.up = edge_value();
         r.dg = edge_value();
         r.lo = edge_value();
         r.rh = edge_value();
      end else begin
         r.up = signed_range(0, 32'h0001_0000);
         r.dg = (sel < 21) ? q_type'(0) : signed_range(32'h0002_0000, 32'h0008_0000);
         r.lo = signed_range(0, 32'h0001_0000);
         r.rh = signed_range(0, 32'h0010_0000);
      end
      r.last = closing;
      return r;
   endfunction

   function automatic void note_mismatch(string field, logic [31:0] want, logic [31:0] got,
                                         int unsigned idx);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("solution %0d %s: expected %h, got %h", idx, field, want, got);
   endfunction

   function automatic void check_result();
      solution_type want;
      if (pending_solutions.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("solution %0d transferred with none pending", rsp_solution_index);
         return;
      end
      want = pending_solutions.pop_front();
      if (rsp_solution_value !== want.sol_value)
         note_mismatch("value", want.sol_value, rsp_solution_value, want.sol_index);
      if (rsp_solution_index !== want.sol_index)
         note_mismatch("index", 32'(want.sol_index), 32'(rsp_solution_index), want.sol_index);
      if (rsp_pivot_zero !== want.pivot_zero)
         note_mismatch("pivot_zero", 32'(want.pivot_zero), 32'(rsp_pivot_zero),
                       want.sol_index);
      if (rsp_last_result !== want.last)
         note_mismatch("last_result", 32'(want.last), 32'(rsp_last_result), want.sol_index);
   endfunction

   // offer one row, idling at random first; valid stays up for the next row
   task automatic send_row(row_stim_type r);
      while (!steady && $urandom_range(99) < 23) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_upper_coef <= r.up;
      req_diag_coef  <= r.dg;
      req_lower_coef <= r.lo;
      req_rhs_value  <= r.rh;
      req_last_row   <= r.last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      eliminate_row(r);
      if (r.known) begin
         void'(pending_solutions.pop_back());
         pending_solutions.push_back('{sol_value: r.x_known, sol_index: '0,
                                       pivot_zero: r.pz_known, last: 1'b1});
      end
   endtask

   task automatic pause_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_solutions.size() != 0) @(posedge clock);
   endtask

   // row side: reset, directed table, random systems, final drain
   initial begin : row_side
      int           rows_sent;
      int           sys;
      int           len;
      int           sel;
      logic         flag_close;
      row_stim_type r;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_upper_coef <= '0;
      req_diag_coef  <= '0;
      req_lower_coef <= '0;
      req_rhs_value  <= '0;
      req_last_row   <= 1'b0;
      steady         <= 1'b0;
      hold_calls     <= 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[k]) send_row(DIRECTED[k]);
      pause_until_drained();

      rows_sent = 0;
      sys       = 0;
      while (rows_sent < RANDOM_ROWS) begin
         // long receiver hold-off over a short system so the block backs up
         if (sys == 3) hold_calls <= hold_calls + 1;
         steady <= (sys >= 20 && sys < 32);
         sel        = $urandom_range(99);
         flag_close = 1'b1;
         if (sys == 3) len = 2;
         else if (sys == 5) begin
            len        = MAX_ROWS;
            flag_close = 1'b0;
         end else if (sel < 3) begin
            len        = MAX_ROWS;
            flag_close = $urandom_range(1);
         end else if (sel < 25) len = $urandom_range(20, 9);
         else len = $urandom_range(8, 1);
         for (int k = 0; k < len; k++) begin
            r = random_row(flag_close && (k == len - 1));
            send_row(r);
         end
         rows_sent += len;
         sys++;
         if (sys == 40) pause_until_drained();
      end

      req_valid <= 1'b0;
      while (pending_solutions.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0)
         $display("tridiagonal_system_solver_top_tb: clean");
      else
         $display("tridiagonal_system_solver_top_tb: errors");
      $finish;
   end

   // result side: check each transfer, then choose ready for the next cycle
   initial begin : result_side
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) check_result();
         if (hold_calls != hold_seen) begin
            hold_seen = hold_calls;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady || ($urandom_range(99) >= 23);
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("tridiagonal_system_solver_top_tb: errors");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule
